FILE: hdl/ntt_pkg.sv
`default_nettype none
package ntt_pkg;

  localparam int unsigned MUL_BITS = 32;

  localparam logic [30:0] MODULUS_RESET = 31'd998244353;
  localparam logic [30:0] ROOT_RESET    = 31'd3;

  typedef enum logic [1:0] {
    REG_MODULUS = 2'd0,
    REG_ROOT    = 2'd1,
    REG_DIR     = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic        start;
    logic [30:0] a;
    logic [31:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [30:0] result;
  } mul_resp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LD_RED,
    S_START,
    S_CP_RD,
    S_CP_WR,
    S_ROOT,
    S_POW_INIT,
    S_POW_BASE,
    S_POW_LOOP,
    S_POW_MRW,
    S_POW_SQW,
    S_ROOT_DONE,
    S_STAGE,
    S_STG_GO,
    S_BF_RD0,
    S_BF_RD1,
    S_BF_MUL,
    S_BF_MULW,
    S_BF_WR0,
    S_BF_WR1,
    S_BF_TWW,
    S_OUT_RD,
    S_OUT_WAIT,
    S_OUT_MULW,
    S_OUT_SHOW
  } state_t;

endpackage
`default_nettype wire

FILE: hdl/ntt_transform.sv
`default_nettype none
// Channel   Direction  Ports
// in        input      in_valid, in_stall, in_sample, in_final_item
// out       output     out_valid, out_stall, out_point, out_position, out_end_of_block,
//                      out_overflowed
// cfg       input      cfg_we, cfg_index, cfg_data
//
// Each modular multiply and each load runs on one shared bit-serial unit. A
// transform of length L takes L*log2(L)/2 butterflies, up to 63 multiplies for
// the root, each stage twiddle and the inverse length, a copy pass and an
// output pass (one multiply per point when inverse).
// rst_n is synchronous and returns the block to idle with an empty store.
// in_stall is high while a transaction is worked on; out holds while out_stall.
module ntt_transform #(
  parameter int unsigned POINTS = 64
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire [31:0] in_sample,
  input  wire        in_final_item,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [30:0] out_point,
  output logic [5:0]  out_position,
  output logic        out_end_of_block,
  output logic        out_overflowed,
  input  wire        cfg_we,
  input  wire [1:0]  cfg_index,
  input  wire [30:0] cfg_data
);

  localparam int unsigned AW = $clog2(POINTS);
  localparam int unsigned SW = $clog2(AW + 2);

  ntt_pkg::state_t state_r, state_nxt;
  ntt_pkg::state_t ret_r, ret_nxt;

  logic [30:0] modulus_r, root_r;
  logic        dir_r;

  logic [AW:0]   fill_r, fill_nxt;
  logic          ovf_r, ovf_nxt;
  logic          final_r, final_nxt;
  logic [SW-1:0] bits_r, bits_nxt;
  logic [AW:0]   len_r, len_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [SW-1:0] s_r, s_nxt;
  logic [AW:0]   base_r, base_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [30:0]   pe_r, pe_nxt;
  logic [30:0]   pb_r, pb_nxt;
  logic [30:0]   pr_r, pr_nxt;
  logic [30:0]   w_r, w_nxt;
  logic [30:0]   wn_r, wn_nxt;
  logic [30:0]   tw_r, tw_nxt;
  logic [30:0]   u_r, u_nxt;
  logic [30:0]   v_r, v_nxt;
  logic [30:0]   outp_r, outp_nxt;

  logic [30:0] store_mem [POINTS];
  logic [30:0] work_mem [2**AW];
  logic [30:0] store_q_r, work_q_r;

  logic          st_we;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [30:0]   st_wdata;
  logic          wk_we;
  logic [AW-1:0] wk_waddr, wk_raddr;
  logic [30:0]   wk_wdata;

  ntt_pkg::mul_req_t  mreq;
  ntt_pkg::mul_resp_t mresp;

  logic [30:0]   one_m;
  logic [30:0]   em1;
  logic [AW:0]   span, half, lo_addr, hi_addr;
  logic [AW-1:0] rev_full, rev;
  logic          last_i;
  logic [31:0]   sum;
  logic [31:0]   diff;
  logic [SW-1:0] bits_calc;
  logic [AW:0]   len_calc;
  logic [AW+5:0] pos_ext;
  logic          accept;

  ntt_mulmod u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .modulus (modulus_r),
    .req     (mreq),
    .resp    (mresp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= ntt_pkg::MODULUS_RESET;
      root_r    <= ntt_pkg::ROOT_RESET;
      dir_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ntt_pkg::REG_MODULUS: modulus_r <= cfg_data;
        ntt_pkg::REG_ROOT:    root_r    <= cfg_data;
        ntt_pkg::REG_DIR:     dir_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    one_m    = (modulus_r < 31'd2) ? 31'd0 : 31'd1;
    em1      = (modulus_r == 31'd0) ? 31'd0 : modulus_r - 31'd1;
    span     = (AW + 1)'(1) << s_r;
    half     = span >> 1;
    lo_addr  = base_r + (AW + 1)'(j_r);
    hi_addr  = lo_addr + half;
    for (int k = 0; k < AW; k++) begin
      rev_full[k] = i_r[AW - 1 - k];
    end
    rev      = rev_full >> ((SW)'(AW) - bits_r);
    last_i   = ((AW + 1)'(i_r) == len_r - (AW + 1)'(1));
    sum      = {1'b0, u_r} + {1'b0, v_r};
    if (sum >= {1'b0, modulus_r}) begin
      sum = sum - {1'b0, modulus_r};
    end
    if (u_r >= v_r) begin
      diff = {1'b0, u_r} - {1'b0, v_r};
    end else begin
      diff = {1'b0, u_r} + {1'b0, modulus_r} - {1'b0, v_r};
    end
    bits_calc = (SW)'(AW);
    len_calc  = (AW + 1)'(1) << AW;
    for (int k = AW; k >= 0; k--) begin
      if (((AW + 1)'(1) << k) >= fill_r) begin
        bits_calc = (SW)'(k);
        len_calc  = (AW + 1)'(1) << k;
      end
    end
    pos_ext = {6'd0, i_r};
    accept  = in_valid && !in_stall;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ntt_pkg::S_IDLE: begin
        if (accept) begin
          if (fill_r != (AW + 1)'(POINTS)) begin
            state_nxt = ntt_pkg::S_LD_RED;
          end else if (in_final_item) begin
            state_nxt = ntt_pkg::S_START;
          end
        end
      end
      ntt_pkg::S_LD_RED: begin
        if (mresp.done) begin
          state_nxt = final_r ? ntt_pkg::S_START : ntt_pkg::S_IDLE;
        end
      end
      ntt_pkg::S_START:     state_nxt = ntt_pkg::S_CP_RD;
      ntt_pkg::S_CP_RD:     state_nxt = ntt_pkg::S_CP_WR;
      ntt_pkg::S_CP_WR:     state_nxt = last_i ? ntt_pkg::S_ROOT : ntt_pkg::S_CP_RD;
      ntt_pkg::S_ROOT:      state_nxt = ntt_pkg::S_POW_INIT;
      ntt_pkg::S_POW_INIT:  state_nxt = ntt_pkg::S_POW_BASE;
      ntt_pkg::S_POW_BASE: begin
        if (mresp.done) begin
          state_nxt = ntt_pkg::S_POW_LOOP;
        end
      end
      ntt_pkg::S_POW_LOOP: begin
        if (pe_r == 31'd0) begin
          state_nxt = ret_r;
        end else if (pe_r[0]) begin
          state_nxt = ntt_pkg::S_POW_MRW;
        end else begin
          state_nxt = ntt_pkg::S_POW_SQW;
        end
      end
      ntt_pkg::S_POW_MRW: begin
        if (mresp.done) begin
          state_nxt = ntt_pkg::S_POW_SQW;
        end
      end
      ntt_pkg::S_POW_SQW: begin
        if (mresp.done) begin
          state_nxt = ntt_pkg::S_POW_LOOP;
        end
      end
      ntt_pkg::S_ROOT_DONE: state_nxt = ntt_pkg::S_STAGE;
      ntt_pkg::S_STAGE: begin
        if (s_r > bits_r) begin
          state_nxt = dir_r ? ntt_pkg::S_POW_INIT : ntt_pkg::S_OUT_RD;
        end else begin
          state_nxt = ntt_pkg::S_POW_INIT;
        end
      end
      ntt_pkg::S_STG_GO:    state_nxt = ntt_pkg::S_BF_RD0;
      ntt_pkg::S_BF_RD0:    state_nxt = ntt_pkg::S_BF_RD1;
      ntt_pkg::S_BF_RD1:    state_nxt = ntt_pkg::S_BF_MUL;
      ntt_pkg::S_BF_MUL:    state_nxt = ntt_pkg::S_BF_MULW;
      ntt_pkg::S_BF_MULW: begin
        if (mresp.done) begin
          state_nxt = ntt_pkg::S_BF_WR0;
        end
      end
      ntt_pkg::S_BF_WR0:    state_nxt = ntt_pkg::S_BF_WR1;
      ntt_pkg::S_BF_WR1:    state_nxt = ntt_pkg::S_BF_TWW;
      ntt_pkg::S_BF_TWW: begin
        if (mresp.done) begin
          if ((AW + 1)'(j_r) == half - (AW + 1)'(1) && base_r + span == len_r) begin
            state_nxt = ntt_pkg::S_STAGE;
          end else begin
            state_nxt = ntt_pkg::S_BF_RD0;
          end
        end
      end
      ntt_pkg::S_OUT_RD:    state_nxt = ntt_pkg::S_OUT_WAIT;
      ntt_pkg::S_OUT_WAIT:  state_nxt = dir_r ? ntt_pkg::S_OUT_MULW : ntt_pkg::S_OUT_SHOW;
      ntt_pkg::S_OUT_MULW: begin
        if (mresp.done) begin
          state_nxt = ntt_pkg::S_OUT_SHOW;
        end
      end
      ntt_pkg::S_OUT_SHOW: begin
        if (!out_stall) begin
          state_nxt = last_i ? ntt_pkg::S_IDLE : ntt_pkg::S_OUT_RD;
        end
      end
      default: state_nxt = ntt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ret_nxt   = ret_r;
    fill_nxt  = fill_r;
    ovf_nxt   = ovf_r;
    final_nxt = final_r;
    bits_nxt  = bits_r;
    len_nxt   = len_r;
    i_nxt     = i_r;
    s_nxt     = s_r;
    base_nxt  = base_r;
    j_nxt     = j_r;
    pe_nxt    = pe_r;
    pb_nxt    = pb_r;
    pr_nxt    = pr_r;
    w_nxt     = w_r;
    wn_nxt    = wn_r;
    tw_nxt    = tw_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    outp_nxt  = outp_r;
    mreq      = '0;
    st_we     = 1'b0;
    st_waddr  = fill_r[AW-1:0];
    st_wdata  = mresp.result;
    st_raddr  = rev;
    wk_we     = 1'b0;
    wk_waddr  = i_r;
    wk_wdata  = store_q_r;
    wk_raddr  = i_r;
    unique case (state_r)
      ntt_pkg::S_IDLE: begin
        if (accept) begin
          final_nxt = in_final_item;
          if (fill_r != (AW + 1)'(POINTS)) begin
            mreq.start = 1'b1;
            mreq.a     = 31'd1;
            mreq.b     = in_sample;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      ntt_pkg::S_LD_RED: begin
        if (mresp.done) begin
          st_we    = 1'b1;
          fill_nxt = fill_r + (AW + 1)'(1);
        end
      end
      ntt_pkg::S_START: begin
        bits_nxt = bits_calc;
        len_nxt  = len_calc;
        i_nxt    = '0;
      end
      ntt_pkg::S_CP_RD: ;
      ntt_pkg::S_CP_WR: begin
        wk_we    = 1'b1;
        wk_wdata = ((AW + 1)'(rev) < fill_r) ? store_q_r : 31'd0;
        if (!last_i) begin
          i_nxt = i_r + (AW)'(1);
        end
      end
      ntt_pkg::S_ROOT: begin
        pb_nxt  = root_r;
        pe_nxt  = (dir_r && modulus_r >= 31'd2) ? modulus_r - 31'd2 : 31'd1;
        ret_nxt = ntt_pkg::S_ROOT_DONE;
      end
      ntt_pkg::S_POW_INIT: begin
        mreq.start = 1'b1;
        mreq.a     = 31'd1;
        mreq.b     = {1'b0, pb_r};
      end
      ntt_pkg::S_POW_BASE: begin
        if (mresp.done) begin
          pb_nxt = mresp.result;
          pr_nxt = one_m;
        end
      end
      ntt_pkg::S_POW_LOOP: begin
        if (pe_r != 31'd0) begin
          mreq.start = 1'b1;
          mreq.a     = pe_r[0] ? pr_r : pb_r;
          mreq.b     = {1'b0, pb_r};
        end
      end
      ntt_pkg::S_POW_MRW: begin
        if (mresp.done) begin
          pr_nxt     = mresp.result;
          mreq.start = 1'b1;
          mreq.a     = pb_r;
          mreq.b     = {1'b0, pb_r};
        end
      end
      ntt_pkg::S_POW_SQW: begin
        if (mresp.done) begin
          pb_nxt = mresp.result;
          pe_nxt = pe_r >> 1;
        end
      end
      ntt_pkg::S_ROOT_DONE: begin
        w_nxt = pr_r;
        s_nxt = (SW)'(1);
      end
      ntt_pkg::S_STAGE: begin
        if (s_r > bits_r) begin
          i_nxt   = '0;
          pb_nxt  = 31'(len_r);
          pe_nxt  = modulus_r - 31'd2;
          ret_nxt = ntt_pkg::S_OUT_RD;
        end else begin
          pb_nxt  = w_r;
          pe_nxt  = em1 >> s_r;
          ret_nxt = ntt_pkg::S_STG_GO;
        end
      end
      ntt_pkg::S_STG_GO: begin
        wn_nxt   = pr_r;
        base_nxt = '0;
        j_nxt    = '0;
        tw_nxt   = one_m;
      end
      ntt_pkg::S_BF_RD0: begin
        wk_raddr = hi_addr[AW-1:0];
      end
      ntt_pkg::S_BF_RD1: begin
        v_nxt    = work_q_r;
        wk_raddr = lo_addr[AW-1:0];
      end
      ntt_pkg::S_BF_MUL: begin
        u_nxt      = work_q_r;
        mreq.start = 1'b1;
        mreq.a     = tw_r;
        mreq.b     = {1'b0, v_r};
      end
      ntt_pkg::S_BF_MULW: begin
        if (mresp.done) begin
          v_nxt = mresp.result;
        end
      end
      ntt_pkg::S_BF_WR0: begin
        wk_we    = 1'b1;
        wk_waddr = lo_addr[AW-1:0];
        wk_wdata = sum[30:0];
      end
      ntt_pkg::S_BF_WR1: begin
        wk_we      = 1'b1;
        wk_waddr   = hi_addr[AW-1:0];
        wk_wdata   = diff[30:0];
        mreq.start = 1'b1;
        mreq.a     = tw_r;
        mreq.b     = {1'b0, wn_r};
      end
      ntt_pkg::S_BF_TWW: begin
        if (mresp.done) begin
          tw_nxt = mresp.result;
          if ((AW + 1)'(j_r) == half - (AW + 1)'(1)) begin
            j_nxt    = '0;
            base_nxt = base_r + span;
            tw_nxt   = one_m;
            if (base_r + span == len_r) begin
              s_nxt = s_r + (SW)'(1);
            end
          end else begin
            j_nxt = j_r + (AW)'(1);
          end
        end
      end
      ntt_pkg::S_OUT_RD: ;
      ntt_pkg::S_OUT_WAIT: begin
        if (dir_r) begin
          mreq.start = 1'b1;
          mreq.a     = pr_r;
          mreq.b     = {1'b0, work_q_r};
        end else begin
          outp_nxt = work_q_r;
        end
      end
      ntt_pkg::S_OUT_MULW: begin
        if (mresp.done) begin
          outp_nxt = mresp.result;
        end
      end
      ntt_pkg::S_OUT_SHOW: begin
        if (!out_stall) begin
          if (last_i) begin
            fill_nxt = '0;
            ovf_nxt  = 1'b0;
          end else begin
            i_nxt = i_r + (AW)'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ntt_pkg::S_IDLE;
      fill_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      ovf_r   <= ovf_nxt;
    end
    ret_r   <= ret_nxt;
    final_r <= final_nxt;
    bits_r  <= bits_nxt;
    len_r   <= len_nxt;
    i_r     <= i_nxt;
    s_r     <= s_nxt;
    base_r  <= base_nxt;
    j_r     <= j_nxt;
    pe_r    <= pe_nxt;
    pb_r    <= pb_nxt;
    pr_r    <= pr_nxt;
    w_r     <= w_nxt;
    wn_r    <= wn_nxt;
    tw_r    <= tw_nxt;
    u_r     <= u_nxt;
    v_r     <= v_nxt;
    outp_r  <= outp_nxt;
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_waddr] <= st_wdata;
    end
    store_q_r <= store_mem[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (wk_we) begin
      work_mem[wk_waddr] <= wk_wdata;
    end
    work_q_r <= work_mem[wk_raddr];
  end

  assign in_stall         = (state_r != ntt_pkg::S_IDLE);
  assign out_valid        = (state_r == ntt_pkg::S_OUT_SHOW);
  assign out_point        = outp_r;
  assign out_position     = pos_ext[5:0];
  assign out_end_of_block = last_i;
  assign out_overflowed   = ovf_r;

endmodule
`default_nettype wire

FILE: hdl/ntt_mulmod.sv
`default_nettype none
module ntt_mulmod (
  input  wire               clk,
  input  wire               rst_n,
  input  wire        [30:0] modulus,
  input  wire ntt_pkg::mul_req_t req,
  output ntt_pkg::mul_resp_t resp
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [30:0] r_r, r_nxt;
  logic [30:0] a_r, a_nxt;
  logic [31:0] b_r, b_nxt;
  logic [32:0] t;
  logic [32:0] m1;
  logic [32:0] m2;
  logic [32:0] red;

  always_comb begin
    m1 = {2'b00, modulus};
    m2 = {1'b0, modulus, 1'b0};
    t  = {1'b0, r_r, 1'b0} + (b_r[31] ? {2'b00, a_r} : 33'd0);
    if (modulus < 31'd2) begin
      red = 33'd0;
    end else if (t >= m2) begin
      red = t - m2;
    end else if (t >= m1) begin
      red = t - m1;
    end else begin
      red = t;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    r_nxt    = r_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      r_nxt    = 31'd0;
      a_nxt    = req.a;
      b_nxt    = req.b;
    end else if (busy_r) begin
      r_nxt   = red[30:0];
      b_nxt   = {b_r[30:0], 1'b0};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(ntt_pkg::MUL_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    r_r   <= r_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign resp.done   = done_r;
  assign resp.result = r_r;

endmodule
`default_nettype wire

FILE: bench/ntt_transform_tb.sv
`default_nettype none
module ntt_transform_tb;

  localparam int NPTS = 64;
  localparam int HANG_LIMIT = 400000;

  typedef struct {
    logic [30:0] point;
    logic [5:0]  position;
    logic        eob;
    logic        ovf;
  } point_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [31:0] in_sample = 0;
  logic        in_final_item = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [30:0] out_point;
  logic [5:0]  out_position;
  logic        out_end_of_block;
  logic        out_overflowed;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = ntt_pkg::REG_MODULUS;
  logic [30:0] cfg_data = 0;

  ntt_transform #(.POINTS(NPTS)) dut (.*);

  always #6 clk = ~clk;

  point_t            expected_points[$];
  bit                failed = 0;
  bit                jitter = 1;
  int                hang_count = 0;
  longint unsigned   fld_mod = 64'(ntt_pkg::MODULUS_RESET);
  longint unsigned   fld_root = 64'(ntt_pkg::ROOT_RESET);
  bit                fld_inverse = 0;
  longint unsigned   loaded[NPTS];
  int                fill = 0;
  bit                dropped = 0;

  function automatic longint unsigned rd(longint unsigned x);
    return (fld_mod < 2) ? 0 : x % fld_mod;
  endfunction

  function automatic longint unsigned mulm(longint unsigned a, longint unsigned b);
    return rd(rd(a) * rd(b));
  endfunction

  function automatic longint unsigned powm(longint unsigned b, longint unsigned e);
    longint unsigned r;
    r = rd(1);
    b = rd(b);
    while (e > 0) begin
      if (e[0]) r = mulm(r, b);
      e = e >> 1;
      b = mulm(b, b);
    end
    return r;
  endfunction

  task automatic transform_block();
    longint unsigned vals[NPTS];
    longint unsigned m, w, wn, tw, u, v, ninv;
    int len, bits, r, span, half;
    point_t p;
    m = fld_mod;
    len = 1;
    bits = 0;
    while (len < fill) begin
      len = len << 1;
      bits++;
    end
    for (int i = 0; i < len; i++) begin
      r = 0;
      for (int k = 0; k < bits; k++)
        if ((i >> k) & 1) r = r | (1 << (bits - 1 - k));
      vals[i] = (r < fill) ? loaded[r] : 0;
    end
    w = (fld_inverse && m >= 2) ? powm(fld_root, m - 2) : rd(fld_root);
    for (span = 2; span <= len; span = span << 1) begin
      wn = powm(w, (m - ((m > 0) ? 1 : 0)) / span);
      half = span >> 1;
      for (int b = 0; b < len; b += span) begin
        tw = rd(1);
        for (int j = 0; j < half; j++) begin
          u = vals[b + j];
          v = mulm(vals[b + j + half], tw);
          vals[b + j] = rd(u + v);
          vals[b + j + half] = rd(u + rd(m) + m - v);
          tw = mulm(tw, wn);
        end
      end
    end
    if (fld_inverse) begin
      ninv = (m >= 2) ? powm(len, m - 2) : 0;
      for (int i = 0; i < len; i++) vals[i] = mulm(vals[i], ninv);
    end
    for (int i = 0; i < len; i++) begin
      p.point = vals[i][30:0];
      p.position = i[5:0];
      p.eob = (i + 1 == len);
      p.ovf = dropped;
      expected_points.push_back(p);
    end
    fill = 0;
    dropped = 0;
  endtask

  task automatic send_sample(input logic [31:0] s, input bit fin);
    if (jitter && $urandom_range(99) < 12) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < 50);
    end
    in_valid <= 1;
    in_sample <= s;
    in_final_item <= fin;
    do @(posedge clk); while (in_stall);
    if (fill < NPTS) begin
      loaded[fill] = rd(64'(s));
      fill++;
    end else begin
      dropped = 1;
    end
    if (fin) transform_block();
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input ntt_pkg::reg_index_t idx, input logic [30:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    case (idx)
      ntt_pkg::REG_MODULUS: fld_mod = 64'(val);
      ntt_pkg::REG_ROOT:    fld_root = 64'(val);
      default:              fld_inverse = val[0];
    endcase
  endtask

  task automatic set_field(input logic [30:0] m, input logic [30:0] g, input bit inv);
    write_reg(ntt_pkg::REG_MODULUS, m);
    write_reg(ntt_pkg::REG_ROOT, g);
    write_reg(ntt_pkg::REG_DIR, {30'd0, inv});
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(7))
      0: return 32'(fld_mod - 1);
      1: return 32'(fld_mod);
      2: return 32'(fld_mod + $urandom_range(3));
      3: return 32'hFFFFFFFF - $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_block(input int n);
    for (int i = 0; i < n; i++) send_sample(pick_sample(), i == n - 1);
  endtask

  task automatic test_directed();
    send_sample(32'd0, 1);
    send_sample(32'hFFFFFFFF, 1);
    send_sample(32'd998244353, 0);
    send_sample(32'hFFFFFFFF, 1);
    send_block(3);
    send_block(5);
    send_block(8);
    drain();
    set_field(31'd3, 31'd2, 1);
    send_block(2);
    send_sample(32'd1, 1);
    drain();
  endtask

  task automatic test_overflow();
    set_field(31'd65537, 31'd3, 0);
    send_block(NPTS);
    for (int i = 0; i < NPTS + 2; i++) send_sample($urandom, i == NPTS + 1);
    send_block(2);
    drain();
    write_reg(ntt_pkg::REG_DIR, 31'd1);
    send_block(NPTS + 1);
    drain();
  endtask

  task automatic test_random();
    logic [30:0] mods[6]  = '{31'd998244353, 31'd3, 31'h7FFFFFFF, 31'd65537, 31'd7681, 31'd17};
    logic [30:0] roots[6] = '{31'd3, 31'd2, 31'h7FFFFFFE, 31'd3, 31'd17, 31'd3};
    int sent, n, k;
    sent = 0;
    k = 0;
    while (sent < 40) begin
      set_field(mods[k % 6], roots[k % 6], 1'(k % 2));
      jitter = (k != 0);
      for (int b = 0; b < 2 && sent < 40; b++) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(17, 70) : $urandom_range(1, 12);
        send_block(n);
        sent += n;
      end
      drain();
      k++;
    end
    jitter = 1;
  endtask

  always @(posedge clk) begin
    point_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected point %0d at position %0d", $time, out_point, out_position);
        failed = 1;
      end else begin
        e = expected_points.pop_front();
        if (out_point !== e.point || out_position !== e.position ||
            out_end_of_block !== e.eob || out_overflowed !== e.ovf) begin
          $display("%0t: expected point %0d pos %0d end %0b ovf %0b",
                   $time, e.point, e.position, e.eob, e.ovf);
          $display("%0t: got point %0d pos %0d end %0b ovf %0b",
                   $time, out_point, out_position, out_end_of_block, out_overflowed);
          failed = 1;
        end
      end
    end
    out_stall <= jitter && ($urandom_range(99) < 12);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) hang_count <= 0;
    else hang_count <= hang_count + 1;
    if (hang_count >= HANG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_random();
    drain();
    repeat (200) @(posedge clk);
    if (!failed && expected_points.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
hdl/ntt_pkg.sv
hdl/ntt_mulmod.sv
hdl/ntt_transform.sv
bench/ntt_transform_tb.sv
